### design/bwsh_pkg.sv
// Package for the byte weighted size histogram: bin count, request codes,
// configuration and result types shared by the cell row, the reducer and the top level.
// No dependencies.
package bwsh_pkg;

  localparam int NUM_BINS   = 64;
  localparam int BIN_W      = $clog2(NUM_BINS);
  localparam int IDX_W      = 6;
  localparam int IDX_CMP_W  = (BIN_W > IDX_W) ? BIN_W : IDX_W;
  localparam int GROUP      = 8;
  localparam int NUM_GROUPS = (NUM_BINS + GROUP - 1) / GROUP;
  localparam int SETTLE_W   = $clog2(NUM_BINS + 2);

  localparam logic [1:0] CFG_MIN_SIZE = 2'd0;
  localparam logic [1:0] CFG_MAX_SIZE = 2'd1;
  localparam logic [1:0] CFG_BIN_STEP = 2'd2;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  typedef struct packed {
    logic [31:0] min_size;
    logic [31:0] max_size;
    logic [31:0] step;      // zero step already replaced by one
  } cfg_t;

  typedef struct packed {
    logic             valid;
    req_e             op;
    logic [31:0]      size;   // already clamped to max_size
    logic             clamped;
    logic [IDX_W-1:0] rd;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [31:0]      bound;
    logic [63:0]      total;
    logic             exists;
  } res_t;

endpackage

### design/bwsh_cell.sv
// One histogram cell: holds one bin total and the bin bound, which it derives
// from its left neighbor every cycle. Depends on bwsh_pkg.
module bwsh_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bwsh_pkg::BIN_W-1:0]    cell_idx_i,
  input  bwsh_pkg::cfg_t                cfg_i,
  input  bwsh_pkg::cmd_t                cmd_i,
  input  logic [31:0]                   bound_i,
  input  logic                          below_i,
  input  logic                          hit_i,
  output logic [31:0]                   bound_o,
  output logic                          below_o,
  output logic                          hit_o,
  output bwsh_pkg::res_t                res_o
);
  import bwsh_pkg::*;

  logic [31:0] bound_q, bound_d;
  logic        below_q, below_d;
  logic [63:0] total_q, total_d;
  logic [32:0] sum;
  logic        is_first, is_last, exists, sel, upd;
  logic [63:0] new_total;
  logic [31:0] bin_bound;

  always_comb begin
    is_first = (cell_idx_i == '0);
    is_last  = (cell_idx_i == BIN_W'(NUM_BINS - 1));
    sum      = {1'b0, bound_i} + {1'b0, cfg_i.step};
    if (is_first) begin
      bound_d = cfg_i.min_size;
      below_d = (cfg_i.min_size < cfg_i.max_size);
    end else begin
      bound_d = sum[31:0];
      below_d = below_i && (sum < {1'b0, cfg_i.max_size});
    end
  end

  assign bound_o = bound_q;
  assign below_o = below_q;
  // Bounds that reach max_size, and every bin after them, catch any size.
  assign hit_o   = !below_q || (bound_q >= cmd_i.size);

  always_comb begin
    exists    = is_first || below_i;
    bin_bound = (below_q && !is_last) ? bound_q : cfg_i.max_size;
    sel       = 1'b0;
    new_total = total_q;
    unique case (cmd_i.op)
      REQ_ADD: begin
        sel       = (is_last || hit_o) && !hit_i;
        new_total = total_q + {32'd0, cmd_i.size};
      end
      REQ_REMOVE: begin
        sel       = (is_last || hit_o) && !hit_i;
        new_total = total_q - {32'd0, cmd_i.size};
      end
      REQ_READ: begin
        sel       = exists && (IDX_CMP_W'(cell_idx_i) == IDX_CMP_W'(cmd_i.rd));
        new_total = total_q;
      end
      REQ_CLEAR: begin
        sel       = 1'b0;
        new_total = '0;
      end
      default: begin
        sel       = 1'b0;
        new_total = total_q;
      end
    endcase
    upd     = cmd_i.valid && ((cmd_i.op == REQ_CLEAR) || (sel && (cmd_i.op != REQ_READ)));
    total_d = upd ? new_total : total_q;
    if (cmd_i.valid && sel) begin
      res_o.idx    = IDX_W'(cell_idx_i);
      res_o.bound  = bin_bound;
      res_o.total  = new_total;
      res_o.exists = 1'b1;
    end else begin
      res_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      below_q <= 1'b0;
      total_q <= '0;
    end else begin
      below_q <= below_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bound_q <= bound_d;
  end

endmodule

### design/bwsh_reduce.sv
// Collects the single selected cell result: a registered OR per group of cells,
// then an OR over the groups. Depends on bwsh_pkg.
module bwsh_reduce (
  input  logic           clk_i,
  input  bwsh_pkg::res_t cell_res_i [bwsh_pkg::NUM_BINS],
  output bwsh_pkg::res_t res_o
);
  import bwsh_pkg::*;

  res_t grp_q [NUM_GROUPS];
  res_t grp_d [NUM_GROUPS];

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_d[g] = '0;
      for (int i = 0; i < GROUP; i++) begin
        if (g * GROUP + i < NUM_BINS) begin
          grp_d[g] = grp_d[g] | cell_res_i[g * GROUP + i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_q[g] <= grp_d[g];
    end
  end

  always_comb begin
    res_o = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      res_o = res_o | grp_q[g];
    end
  end

endmodule

### design/byte_weighted_size_histogram.sv
// Top level of the byte weighted size histogram: configuration registers,
// request register, the row of bwsh_cell instances and the bwsh_reduce result path.
// Depends on bwsh_pkg, bwsh_cell and bwsh_reduce.
//
// Usage. A request (add, remove, read one bin, clear all) is transferred at a
// rising edge where start is high and busy is low. Its single result appears
// on the result ports, marked by done_o, which is high for exactly one cycle; the
// receiver cannot stall, so nothing backs up. Busy stays high until the result
// strobe, so a new request is not taken before the result of the last one. The
// result passes through the request register, the cell update with the group
// stage of the result tree, and the output register.
// Bin bounds are not computed per request: each cell builds its bound from its
// left neighbor's bound plus the step, one cell further per clock. After reset
// and after every configuration transfer the row must settle; busy is held high
// while the settling count runs down, and configuration transfers are still taken.
// Reset clears all bin totals and loads the default bounds. Configuration must
// be written only while no request is in flight; the block itself does not
// enforce it. Totals are kept across a change and read under the new bounds.
module byte_weighted_size_histogram (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] item_size_i,
  input  logic [5:0]  read_bin_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        done_o,
  output logic [5:0]  bin_index_o,
  output logic [31:0] bin_bound_o,
  output logic [63:0] bin_total_o,
  output logic        bin_exists_o,
  output logic        size_clamped_o
);
  import bwsh_pkg::*;

  logic [31:0]         min_q, max_q, step_q;
  logic [SETTLE_W-1:0] settle_q, settle_d;
  cfg_t                cfg;
  cmd_t                cmd_q, cmd_d, cmd1_q;
  logic                accept, cfg_write;
  res_t                red_res;
  logic                done_q;
  logic [5:0]          idx_q;
  logic [31:0]         bound_q;
  logic [63:0]         total_q;
  logic                exists_q, clamped_q;

  // Neighbor links of the cell row.
  logic [31:0] bound_w [NUM_BINS];
  logic        below_w [NUM_BINS];
  logic        hit_w   [NUM_BINS];
  res_t        cell_res [NUM_BINS];

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign busy        = cmd_q.valid || cmd1_q.valid || (settle_q != '0);
  assign accept      = start && !busy;

  always_comb begin
    cfg.min_size = min_q;
    cfg.max_size = max_q;
    cfg.step     = (step_q == '0) ? 32'd1 : step_q;
  end

  // Clamp happens on the way in for add and remove, so those requests reach the cells with sizes up to max_size.
  always_comb begin
    cmd_d.valid   = accept;
    cmd_d.op      = req_e'(req_type_i);
    cmd_d.rd      = read_bin_i;
    cmd_d.clamped = 1'b0;
    cmd_d.size    = item_size_i;
    if ((cmd_d.op == REQ_ADD || cmd_d.op == REQ_REMOVE) && item_size_i > max_q) begin
      cmd_d.clamped = 1'b1;
      cmd_d.size    = max_q;
    end
  end

  // A configuration transfer restarts the settling count of the bound chain.
  always_comb begin
    if (cfg_write) begin
      settle_d = SETTLE_W'(NUM_BINS + 1);
    end else if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= 32'd64;
      max_q    <= 32'd2048;
      step_q   <= 32'd64;
      settle_q <= SETTLE_W'(NUM_BINS + 1);
      cmd_q    <= '0;
      cmd1_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index_i)
          CFG_MIN_SIZE: min_q  <= cfg_data_i;
          CFG_MAX_SIZE: max_q  <= cfg_data_i;
          CFG_BIN_STEP: step_q <= cfg_data_i;
          default: ;
        endcase
      end
      settle_q <= settle_d;
      cmd_q    <= cmd_d;
      cmd1_q   <= cmd_q;
      done_q   <= cmd1_q.valid;
    end
  end

  for (genvar j = 0; j < NUM_BINS; j++) begin : g_cell
    logic [31:0] bound_in;
    logic        below_in;
    logic        hit_in;
    if (j == 0) begin : g_first
      assign bound_in = '0;
      assign below_in = 1'b0;
      assign hit_in   = 1'b0;
    end else begin : g_rest
      assign bound_in = bound_w[j-1];
      assign below_in = below_w[j-1];
      assign hit_in   = hit_w[j-1];
    end
    bwsh_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (BIN_W'(j)),
      .cfg_i      (cfg),
      .cmd_i      (cmd_q),
      .bound_i    (bound_in),
      .below_i    (below_in),
      .hit_i      (hit_in),
      .bound_o    (bound_w[j]),
      .below_o    (below_w[j]),
      .hit_o      (hit_w[j]),
      .res_o      (cell_res[j])
    );
  end

  bwsh_reduce u_reduce (
    .clk_i      (clk_i),
    .cell_res_i (cell_res),
    .res_o      (red_res)
  );

  // A read reports the requested index even when that bin does not exist;
  // a clear reports all zero fields.
  always_ff @(posedge clk_i) begin
    if (cmd1_q.valid) begin
      unique case (cmd1_q.op)
        REQ_READ:  idx_q <= cmd1_q.rd;
        REQ_CLEAR: idx_q <= '0;
        default:   idx_q <= red_res.idx;
      endcase
      bound_q   <= red_res.bound;
      total_q   <= red_res.total;
      exists_q  <= red_res.exists;
      clamped_q <= cmd1_q.clamped;
    end
  end

  assign done_o         = done_q;
  assign bin_index_o    = idx_q;
  assign bin_bound_o    = bound_q;
  assign bin_total_o    = total_q;
  assign bin_exists_o   = exists_q;
  assign size_clamped_o = clamped_q;

endmodule
